>>> hdl/jpc_pkg.sv
package jpc_pkg;

  localparam int SEG_COUNT_BITS_DEF = 10;

  localparam int POS_W      = 16;
  localparam int TRQ_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // shared multiplier: 17 x 17 signed
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;

  // rescaled PD terms and the final torque sum
  localparam int TERM_W = 24;
  localparam int SUM_W  = 27;

  // segment divider: 16 quotient bits, two per cycle
  localparam int QUOT_W    = 16;
  localparam int DIV_ITERS = QUOT_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  localparam logic [3:0]  RND_Q12   = 4'd12;
  localparam logic [3:0]  RND_Q10   = 4'd10;
  localparam logic [12:0] ALPHA_ONE = 13'd4096;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN      = 3'd0,
    CFG_KD_GAIN      = 3'd1,
    CFG_STEP_LIMIT   = 3'd2,
    CFG_INTERP_TICKS = 3'd3,
    CFG_HAPTIC_SCALE = 3'd4,
    CFG_HAPTIC_ALPHA = 3'd5,
    CFG_HAPTIC_LIMIT = 3'd6,
    CFG_POS_WINDOW   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] kd_gain;
    logic [14:0] step_limit;
    logic [9:0]  interp_ticks;
    logic [15:0] haptic_scale;
    logic [12:0] haptic_alpha;
    logic [14:0] haptic_limit;
    logic [31:0] pos_window;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    kp_gain:      16'd2560,
    kd_gain:      16'd128,
    step_limit:   15'd40,
    interp_ticks: 10'd20,
    haptic_scale: 16'd0,
    haptic_alpha: 13'd4096,
    haptic_limit: 15'd0,
    pos_window:   32'h7FFF_8000
  };

  typedef enum logic [2:0] {
    MUL_SEG,
    MUL_HAP,
    MUL_ALPHA,
    MUL_KD,
    MUL_KP
  } mul_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEGMUL,
    ST_DIVLD,
    ST_DIV,
    ST_SLEW,
    ST_KPMUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    mul_en;
    mul_op_t mul_op;
    logic    div_load;
    logic    div_step;
    logic    hap_clamp;
    logic    hf_update;
    logic    kd_round;
    logic    slew;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // round to nearest, halves away from zero
  function automatic logic signed [PROD_W-1:0] round_shr(input logic signed [PROD_W-1:0] v,
                                                        input logic [3:0] sh);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] half;
    logic [PROD_W-1:0] r;
    mag  = v[PROD_W-1] ? (~v + 1'b1) : v;
    half = {{(PROD_W-1){1'b0}}, 1'b1} << (sh - 4'd1);
    r    = (mag + half) >> sh;
    return v[PROD_W-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [TRQ_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] s;
    s = v;
    if (s > SAT_HI) s = SAT_HI;
    if (s < SAT_LO) s = SAT_LO;
    return s[TRQ_W-1:0];
  endfunction

endpackage

>>> hdl/jpc_cfg_regs.sv
module jpc_cfg_regs
  import jpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KP_GAIN:      cfg_nxt.kp_gain      = cfg_data[15:0];
        CFG_KD_GAIN:      cfg_nxt.kd_gain      = cfg_data[15:0];
        CFG_STEP_LIMIT:   cfg_nxt.step_limit   = cfg_data[14:0];
        CFG_INTERP_TICKS: cfg_nxt.interp_ticks = cfg_data[9:0];
        CFG_HAPTIC_SCALE: cfg_nxt.haptic_scale = cfg_data[15:0];
        CFG_HAPTIC_ALPHA: cfg_nxt.haptic_alpha = cfg_data[12:0];
        CFG_HAPTIC_LIMIT: cfg_nxt.haptic_limit = cfg_data[14:0];
        CFG_POS_WINDOW:   cfg_nxt.pos_window   = cfg_data[31:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hdl/jpc_ctrl.sv
module jpc_ctrl
  import jpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  // side operations run while the divider iterates
  localparam logic [DIV_CNT_W-1:0] CNT_HAP_CLAMP = DIV_CNT_W'(0);
  localparam logic [DIV_CNT_W-1:0] CNT_ALPHA_MUL = DIV_CNT_W'(1);
  localparam logic [DIV_CNT_W-1:0] CNT_HF_UPD    = DIV_CNT_W'(2);
  localparam logic [DIV_CNT_W-1:0] CNT_KD_MUL    = DIV_CNT_W'(3);
  localparam logic [DIV_CNT_W-1:0] CNT_KD_RND    = DIV_CNT_W'(4);
  localparam logic [DIV_CNT_W-1:0] CNT_LAST      = DIV_CNT_W'(DIV_ITERS - 1);

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    cmd.mul_op = MUL_SEG;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SEGMUL;
        end
      end
      ST_SEGMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SEG;
        state_nxt  = ST_DIVLD;
      end
      ST_DIVLD: begin
        cmd.div_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_op   = MUL_HAP;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        case (cnt_r)
          CNT_HAP_CLAMP: cmd.hap_clamp = 1'b1;
          CNT_ALPHA_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_ALPHA;
          end
          CNT_HF_UPD: cmd.hf_update = 1'b1;
          CNT_KD_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_KD;
          end
          CNT_KD_RND: cmd.kd_round = 1'b1;
          default: cmd.div_step = 1'b1;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = ST_SLEW;
      end
      ST_SLEW: begin
        cmd.slew  = 1'b1;
        state_nxt = ST_KPMUL;
      end
      ST_KPMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_KP;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> hdl/jpc_datapath.sv
module jpc_datapath
  import jpc_pkg::*;
#(
  parameter int SEG_COUNT_BITS = SEG_COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  dp_cmd_t                 cmd,
  output dp_sts_t                 sts,
  input  logic                    in_direct_mode,
  input  logic signed [POS_W-1:0] in_target_pos,
  input  logic signed [POS_W-1:0] in_meas_pos,
  input  logic signed [POS_W-1:0] in_meas_vel,
  input  logic signed [TRQ_W-1:0] in_meas_torque,
  input  logic signed [TRQ_W-1:0] in_grav_torque,
  input  logic signed [TRQ_W-1:0] in_haptic_torque,
  input  logic                    in_haptic_fresh,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_cmd_pos,
  output logic signed [TRQ_W-1:0] out_ff_torque,
  output logic signed [TRQ_W-1:0] out_interaction_effort
);

  localparam int                SEG_W   = SEG_COUNT_BITS;
  localparam int                CMP_W   = 17;
  localparam logic [SEG_W-1:0]  SEG_CAP = '1;
  localparam int                DIVD_W  = QUOT_W + SEG_W;

  // persistent joint state
  logic signed [POS_W-1:0] cmd_r, cmd_nxt;
  logic signed [POS_W-1:0] seg_start_r, seg_start_nxt;
  logic signed [POS_W-1:0] seg_end_r, seg_end_nxt;
  logic signed [POS_W-1:0] last_target_r, last_target_nxt;
  logic signed [TRQ_W-1:0] hf_r, hf_nxt;
  logic [SEG_W-1:0]        seg_count_r, seg_count_nxt;
  logic                    seeded_r, seeded_nxt;
  logic                    pending_r, pending_nxt;

  // per-tick operands
  logic                    direct_r;
  logic signed [POS_W-1:0] target_r, mpos_r, mvel_r;
  logic signed [TRQ_W-1:0] mtrq_r, grav_r, hraw_r;
  logic [SEG_W-1:0]        c_r, n_r;
  logic                    bypass_r;

  // arithmetic
  logic signed [PROD_W-1:0] prod_r;
  logic signed [TRQ_W-1:0]  bounded_r;
  logic signed [TERM_W-1:0] kd_term_r;
  logic [SEG_W-1:0]         rem_r, rem_nxt;
  logic [QUOT_W-1:0]        dsh_r, dsh_nxt;
  logic [QUOT_W-1:0]        q_r, q_nxt;

  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_cmd_r;
  logic signed [TRQ_W-1:0] out_ff_r, out_eff_r;

  // accept-time decisions
  logic signed [POS_W-1:0] cmd_eff, start_eff, end_eff, win_lo, win_hi, t_clamp;
  logic                    pending_eff, start_seg;
  logic [SEG_W-1:0]        cnt_new, n_new, c_new;

  always_comb begin
    cmd_eff     = seeded_r ? cmd_r : in_meas_pos;
    start_eff   = seeded_r ? seg_start_r : in_meas_pos;
    end_eff     = seeded_r ? seg_end_r : in_meas_pos;
    pending_eff = !seeded_r || pending_r;
    win_lo      = $signed(cfg.pos_window[15:0]);
    win_hi      = $signed(cfg.pos_window[31:16]);
    t_clamp     = in_target_pos;
    if (t_clamp < win_lo) t_clamp = win_lo;
    if (t_clamp > win_hi) t_clamp = win_hi;
    start_seg = !in_direct_mode && (pending_eff || (in_target_pos != last_target_r));
    cnt_new   = start_seg ? '0 : seg_count_r;
    n_new     = (CMP_W'(cfg.interp_ticks) < CMP_W'(SEG_CAP)) ? SEG_W'(cfg.interp_ticks)
                                                             : SEG_CAP;
    c_new     = (cnt_new < n_new) ? cnt_new : n_new;
  end

  // segment difference, sign and magnitude
  logic signed [POS_W:0] diff, diff_neg;
  logic [POS_W-1:0]      diff_mag;

  assign diff     = POS_W'(seg_end_r) - POS_W'(seg_start_r) + (POS_W+1)'(0);
  assign diff_neg = -diff;
  assign diff_mag = diff[POS_W] ? diff_neg[POS_W-1:0] : diff[POS_W-1:0];

  // shared multiplier operand select
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [12:0]              alpha_eff;

  assign alpha_eff = (cfg.haptic_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.haptic_alpha;

  always_comb begin
    case (cmd.mul_op)
      MUL_SEG: begin
        mul_a = $signed({1'b0, diff_mag});
        mul_b = $signed({{(MUL_W-SEG_W){1'b0}}, c_r});
      end
      MUL_HAP: begin
        mul_a = $signed({1'b0, cfg.haptic_scale});
        mul_b = MUL_W'(hraw_r);
      end
      MUL_ALPHA: begin
        mul_a = $signed({4'b0000, alpha_eff});
        mul_b = MUL_W'(bounded_r) - MUL_W'(hf_r);
      end
      MUL_KD: begin
        mul_a = $signed({1'b0, cfg.kd_gain});
        mul_b = MUL_W'(mvel_r);
      end
      MUL_KP: begin
        mul_a = $signed({1'b0, cfg.kp_gain});
        mul_b = MUL_W'(cmd_r) - MUL_W'(mpos_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // restoring divider, two quotient bits per step
  always_comb begin
    logic [SEG_W:0]    t;
    logic [SEG_W-1:0]  r;
    logic [QUOT_W-1:0] d;
    logic [QUOT_W-1:0] q;
    logic              qb;
    r = rem_r;
    d = dsh_r;
    q = q_r;
    for (int k = 0; k < 2; k++) begin
      t = {r, d[QUOT_W-1]};
      d = d << 1;
      qb = (t >= {1'b0, n_r});
      if (qb) t = t - {1'b0, n_r};
      r = t[SEG_W-1:0];
      q = {q[QUOT_W-2:0], qb};
    end
    rem_nxt = r;
    dsh_nxt = d;
    q_nxt   = q;
  end

  // rounding of the product register
  logic signed [PROD_W-1:0] rnd12, rnd10, hap_raw, hap_lim;

  assign rnd12   = round_shr(prod_r, RND_Q12);
  assign rnd10   = round_shr(prod_r, RND_Q10);
  assign hap_lim = PROD_W'($signed({1'b0, cfg.haptic_limit}));

  always_comb begin
    hap_raw = rnd12;
    if (hap_raw > hap_lim) hap_raw = hap_lim;
    if (hap_raw < -hap_lim) hap_raw = -hap_lim;
  end

  // slew toward the desired point
  logic signed [POS_W:0] q_off, q_des, err, step;

  always_comb begin
    q_off = diff[POS_W] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    if (bypass_r) begin
      q_des = direct_r ? (POS_W+1)'(target_r) : (POS_W+1)'(seg_end_r);
    end else begin
      q_des = (POS_W+1)'(seg_start_r) + q_off;
    end
    step = $signed({2'b00, cfg.step_limit});
    err  = q_des - (POS_W+1)'(cmd_r);
    if (err > step) err = step;
    if (err < -step) err = -step;
  end

  // final torque sums
  logic signed [SUM_W-1:0] pd_sum, eff_sum, ff_sum;

  always_comb begin
    ff_sum  = SUM_W'(grav_r) + SUM_W'(hf_r);
    pd_sum  = SUM_W'($signed(rnd12[TERM_W-1:0])) - SUM_W'(kd_term_r) + ff_sum;
    eff_sum = SUM_W'(mtrq_r) - pd_sum;
  end

  // state next values
  always_comb begin
    cmd_nxt         = cmd_r;
    seg_start_nxt   = seg_start_r;
    seg_end_nxt     = seg_end_r;
    last_target_nxt = last_target_r;
    seg_count_nxt   = seg_count_r;
    seeded_nxt      = seeded_r;
    pending_nxt     = pending_r;
    hf_nxt          = hf_r;
    if (cmd.accept) begin
      seeded_nxt    = 1'b1;
      cmd_nxt       = cmd_eff;
      seg_start_nxt = start_eff;
      seg_end_nxt   = end_eff;
      pending_nxt   = pending_eff;
      if (in_direct_mode) begin
        pending_nxt = 1'b1;
      end else begin
        if (start_seg) begin
          seg_start_nxt = cmd_eff;
          seg_end_nxt   = t_clamp;
          pending_nxt   = 1'b0;
        end
        last_target_nxt = in_target_pos;
        seg_count_nxt   = (cnt_new < SEG_CAP) ? cnt_new + 1'b1 : cnt_new;
      end
    end
    if (cmd.slew) cmd_nxt = cmd_r + err[POS_W-1:0];
    if (cmd.hf_update) hf_nxt = hf_r + rnd12[TRQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r         <= '0;
      seg_start_r   <= '0;
      seg_end_r     <= '0;
      last_target_r <= '0;
      seg_count_r   <= '0;
      seeded_r      <= 1'b0;
      pending_r     <= 1'b0;
      hf_r          <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      cmd_r         <= cmd_nxt;
      seg_start_r   <= seg_start_nxt;
      seg_end_r     <= seg_end_nxt;
      last_target_r <= last_target_nxt;
      seg_count_r   <= seg_count_nxt;
      seeded_r      <= seeded_nxt;
      pending_r     <= pending_nxt;
      hf_r          <= hf_nxt;
      out_valid_r   <= cmd.finish || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      direct_r <= in_direct_mode;
      target_r <= in_target_pos;
      mpos_r   <= in_meas_pos;
      mvel_r   <= in_meas_vel;
      mtrq_r   <= in_meas_torque;
      grav_r   <= in_grav_torque;
      hraw_r   <= in_haptic_fresh ? in_haptic_torque : '0;
      c_r      <= c_new;
      n_r      <= n_new;
      bypass_r <= in_direct_mode || (n_new == '0);
    end
    if (cmd.mul_en) prod_r <= prod_nxt;
    if (cmd.div_load) begin
      rem_r <= prod_r[DIVD_W-1:QUOT_W];
      dsh_r <= prod_r[QUOT_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dsh_r <= dsh_nxt;
      q_r   <= q_nxt;
    end
    if (cmd.hap_clamp) bounded_r <= hap_raw[TRQ_W-1:0];
    if (cmd.kd_round) kd_term_r <= rnd10[TERM_W-1:0];
    if (cmd.finish) begin
      out_cmd_r <= cmd_r;
      out_ff_r  <= sat16(ff_sum);
      out_eff_r <= sat16(eff_sum);
    end
  end

  assign sts.out_free           = !out_valid_r || !out_stall;
  assign out_valid              = out_valid_r;
  assign out_cmd_pos            = out_cmd_r;
  assign out_ff_torque          = out_ff_r;
  assign out_interaction_effort = out_eff_r;

endmodule

>>> hdl/joint_pd_gravity_haptic_control.sv
// Each accepted input beat runs in order through the segment product on the one shared
//   multiplier, the two-bit-per-cycle segment divider, the slew and the PD product.
//   A new input beat is taken only once the previous tick is in the output register.
// A waiting result does not block the next input beat; only a second finished tick waits.
// Reset: rst_n synchronous, active low; clears joint state, output valid and the
//   controller, and loads the configuration registers with their defaults.
module joint_pd_gravity_haptic_control
  import jpc_pkg::*;
#(
  parameter int SEG_COUNT_BITS = SEG_COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // tick input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_direct_mode,
  input  logic signed [POS_W-1:0] in_target_pos,
  input  logic signed [POS_W-1:0] in_meas_pos,
  input  logic signed [POS_W-1:0] in_meas_vel,
  input  logic signed [TRQ_W-1:0] in_meas_torque,
  input  logic signed [TRQ_W-1:0] in_grav_torque,
  input  logic signed [TRQ_W-1:0] in_haptic_torque,
  input  logic                    in_haptic_fresh,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_cmd_pos,
  output logic signed [TRQ_W-1:0] out_ff_torque,
  output logic signed [TRQ_W-1:0] out_interaction_effort,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Register file: always ready, write only while no tick is in flight.
  jpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: accept a beat, run the segment product and divider, overlap the
  // haptic filter and damping term with the divider, then slew, PD and finish.
  jpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: joint state, one 17x17 multiplier, divider and the output register.
  jpc_datapath #(
    .SEG_COUNT_BITS (SEG_COUNT_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_direct_mode         (in_direct_mode),
    .in_target_pos          (in_target_pos),
    .in_meas_pos            (in_meas_pos),
    .in_meas_vel            (in_meas_vel),
    .in_meas_torque         (in_meas_torque),
    .in_grav_torque         (in_grav_torque),
    .in_haptic_torque       (in_haptic_torque),
    .in_haptic_fresh        (in_haptic_fresh),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_cmd_pos            (out_cmd_pos),
    .out_ff_torque          (out_ff_torque),
    .out_interaction_effort (out_interaction_effort)
  );

endmodule

>>> hdl/jpc_checker.sv
module jpc_checker
  import jpc_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [POS_W-1:0] out_cmd_pos,
  input logic signed [TRQ_W-1:0] out_ff_torque,
  input logic signed [TRQ_W-1:0] out_interaction_effort
);

  // busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a tick is in flight");

  // the tick is still being worked on when its result stage is reached
  a_busy_whole_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##13 in_stall)
    else $error("tick finished early");

  // a result only appears at the end of a tick
  a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a tick in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_cmd_pos) &&
                                  $stable(out_ff_torque) && $stable(out_interaction_effort)))
    else $error("stalled result changed");

  // reset drops the output beat
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind joint_pd_gravity_haptic_control jpc_checker u_chk (.*);
